// File: sv/bae_pkg.sv
// shared types and constants of the binary arithmetic encoder
// no dependencies
package bae_pkg;

    localparam int unsigned PREC      = 16;
    localparam int unsigned PEND_MAX  = 47;
    localparam int unsigned PEND_W    = 6;
    localparam int unsigned CNT_W     = 32;
    localparam int unsigned MAX_RES   = 64;
    localparam int unsigned RES_AW    = $clog2(MAX_RES);
    localparam int unsigned GUARD_MAX = PREC + 2;
    localparam int unsigned GUARD_W   = $clog2(GUARD_MAX + 1);
    localparam int unsigned STEP_W    = $clog2(PREC);
    localparam int unsigned PROD_W    = PREC + CNT_W;
    localparam int unsigned REM_W     = CNT_W + 1;

    localparam logic [PREC-1:0] IV_MAX  = {PREC{1'b1}};
    localparam logic [PREC-1:0] IV_QTR  = IV_MAX >> 2;
    localparam logic [PREC-1:0] IV_3QTR = PREC'(3 * (IV_MAX >> 2));
    localparam logic [PREC-1:0] IV_QTR1 = PREC'((IV_MAX >> 2) + 1);
    localparam logic [15:0]     FIXED_DIV = 16'hFFFF;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_LIMIT   = 2'd1;
    localparam logic [1:0] ST_PENDOVF = 2'd2;

    localparam logic REQ_ENCODE = 1'b0;
    localparam logic REQ_FINISH = 1'b1;

    localparam logic REG_MODE  = 1'b0;
    localparam logic REG_FIXED = 1'b1;

    typedef struct packed {
        logic req_type;
        logic symbol_bit;
    } t_bae_req;

    typedef struct packed {
        logic       out_bit;
        logic       has_bit;
        logic [1:0] status;
        logic       last;
    } t_bae_res;

    typedef struct packed {
        logic is_finish;
        logic symbol;
    } t_bae_item;

    typedef struct packed {
        logic      valid;
        t_bae_item item;
    } t_bae_queue;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_DIV, S_SPLIT, S_NORM, S_EMIT, S_FIN, S_RD, S_SHOW, S_WAIT
    } t_bae_state;

endpackage

// File: sv/bae_ram.sv
// generic single-write, single-read memory with registered read
// no dependencies
module bae_ram #(
    parameter int unsigned WIDTH = 1,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/bae_front.sv
// front end: accepts requests, classifies them and queues them for the core
// depends on bae_pkg
module bae_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  bae_pkg::t_bae_req   i_in_req,
    output logic                o_in_stall,
    output bae_pkg::t_bae_queue o_head,
    input  logic                i_pop
);

    bae_pkg::t_bae_item r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;
    bae_pkg::t_bae_item w_item;

    always_comb begin
        w_item.is_finish = (i_in_req.req_type == bae_pkg::REQ_FINISH);
        w_item.symbol    = i_in_req.symbol_bit;
    end

    assign o_in_stall  = (r_cnt == 2'd2);
    assign w_push      = i_in_valid && !o_in_stall;
    assign w_pop       = i_pop && (r_cnt != 2'd0);
    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_item;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule

// File: sv/bae_core.sv
// back end: interval split by shift-add multiply and restoring divide,
// renormalization, bit buffering and result delivery; depends on bae_pkg, bae_ram
module bae_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adaptive,
    input  logic [15:0]         i_fixed_p,
    input  bae_pkg::t_bae_queue i_head,
    output logic                o_pop,
    output logic                o_out_valid,
    output bae_pkg::t_bae_res   o_out_res,
    input  logic                i_out_stall
);

    localparam int unsigned P = bae_pkg::PREC;

    bae_pkg::t_bae_state r_state, n_state;

    logic [P-1:0]                 r_low, r_high, r_mq, r_quo;
    logic [bae_pkg::CNT_W-1:0]    r_zc, r_oc;
    logic [bae_pkg::PEND_W-1:0]   r_pend, r_erem;
    logic [bae_pkg::PROD_W-1:0]   r_acc;
    logic [bae_pkg::REM_W-1:0]    r_rem;
    logic [bae_pkg::STEP_W-1:0]   r_step;
    logic [bae_pkg::GUARD_W-1:0]  r_guard;
    logic [bae_pkg::RES_AW:0]     r_nbits;
    logic [bae_pkg::RES_AW-1:0]   r_rdk;
    logic                         r_sym, r_fin, r_ebit;
    logic [1:0]                   r_stat;
    logic                         r_out_valid;
    bae_pkg::t_bae_res            r_out;

    logic                         w_limit, w_e12, w_e3, w_step_end, w_accept;
    logic [bae_pkg::CNT_W-1:0]    w_mcand;
    logic [bae_pkg::PROD_W-1:0]   w_acc_nx;
    logic [bae_pkg::REM_W-1:0]    w_div;
    logic [bae_pkg::REM_W:0]      w_rsh, w_rsub;
    logic [P-1:0]                 w_mid, w_h3, w_l3;
    logic [bae_pkg::PEND_W-1:0]   w_pend_inc;
    logic                         w_pend_ovf;
    logic                         w_we, w_wdata, w_rdata;

    assign w_limit  = r_sym ? r_oc[bae_pkg::CNT_W-1] : r_zc[bae_pkg::CNT_W-1];
    assign w_mcand  = i_adaptive ? r_zc : bae_pkg::CNT_W'(i_fixed_p);
    assign w_acc_nx = {r_acc[bae_pkg::PROD_W-2:0], 1'b0}
                      + (r_mq[P-1] ? bae_pkg::PROD_W'(w_mcand) : '0);
    assign w_div    = i_adaptive ? ({1'b0, r_zc} + {1'b0, r_oc})
                                 : bae_pkg::REM_W'(bae_pkg::FIXED_DIV);
    assign w_rsh    = {r_rem, r_acc[P-1]};
    assign w_rsub   = w_rsh - {1'b0, w_div};
    assign w_step_end = (r_step == bae_pkg::STEP_W'(P - 1));
    assign w_mid    = r_low + r_quo;
    assign w_e12    = (r_high[P-1] == r_low[P-1]);
    assign w_e3     = (r_high <= bae_pkg::IV_3QTR) && (r_low > bae_pkg::IV_QTR);
    assign w_h3     = r_high - bae_pkg::IV_QTR1;
    assign w_l3     = r_low - bae_pkg::IV_QTR1;
    assign w_pend_ovf = (r_pend >= bae_pkg::PEND_W'(bae_pkg::PEND_MAX));
    assign w_pend_inc = w_pend_ovf ? bae_pkg::PEND_W'(bae_pkg::PEND_MAX) : r_pend + 1'b1;
    assign w_accept = r_out_valid && !i_out_stall;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bae_pkg::S_IDLE: begin
                if (i_head.valid) begin
                    n_state = i_head.item.is_finish ? bae_pkg::S_FIN : bae_pkg::S_MUL;
                end
            end
            bae_pkg::S_MUL: begin
                if (w_limit) n_state = bae_pkg::S_RD;
                else if (w_step_end) n_state = bae_pkg::S_DIV;
            end
            bae_pkg::S_DIV:   if (w_step_end) n_state = bae_pkg::S_SPLIT;
            bae_pkg::S_SPLIT: n_state = bae_pkg::S_NORM;
            bae_pkg::S_NORM: begin
                if (r_guard == bae_pkg::GUARD_W'(bae_pkg::GUARD_MAX)) n_state = bae_pkg::S_RD;
                else if (w_e12) begin
                    if (r_pend != '0) n_state = bae_pkg::S_EMIT;
                end else if (!w_e3) n_state = bae_pkg::S_RD;
            end
            bae_pkg::S_EMIT: begin
                if (r_erem == bae_pkg::PEND_W'(1)) begin
                    n_state = r_fin ? bae_pkg::S_RD : bae_pkg::S_NORM;
                end
            end
            bae_pkg::S_FIN:  n_state = bae_pkg::S_EMIT;
            bae_pkg::S_RD:   n_state = bae_pkg::S_SHOW;
            bae_pkg::S_SHOW: n_state = bae_pkg::S_WAIT;
            bae_pkg::S_WAIT: begin
                if (w_accept) n_state = r_out.last ? bae_pkg::S_IDLE : bae_pkg::S_RD;
            end
            default: n_state = bae_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_pop   = 1'b0;
        w_we    = 1'b0;
        w_wdata = 1'b0;
        unique case (r_state)
            bae_pkg::S_IDLE: o_pop = i_head.valid;
            bae_pkg::S_NORM: begin
                w_we    = w_e12 && (r_guard != bae_pkg::GUARD_W'(bae_pkg::GUARD_MAX));
                w_wdata = r_high[P-1];
            end
            bae_pkg::S_EMIT: begin
                w_we    = 1'b1;
                w_wdata = ~r_ebit;
            end
            bae_pkg::S_FIN: begin
                w_we    = 1'b1;
                w_wdata = (r_low >= bae_pkg::IV_QTR);
            end
            default: ;
        endcase
        w_we = w_we && !r_nbits[bae_pkg::RES_AW];
    end

    bae_ram #(.WIDTH(1), .DEPTH(bae_pkg::MAX_RES)) u_buf (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_nbits[bae_pkg::RES_AW-1:0]),
        .i_wdata (w_wdata),
        .i_raddr (r_rdk),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bae_pkg::S_IDLE;
            r_low       <= '0;
            r_high      <= bae_pkg::IV_MAX;
            r_zc        <= bae_pkg::CNT_W'(1);
            r_oc        <= bae_pkg::CNT_W'(1);
            r_pend      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_we) r_nbits <= r_nbits + 1'b1;
            unique case (r_state)
                bae_pkg::S_IDLE: begin
                    r_sym   <= i_head.item.symbol;
                    r_fin   <= i_head.item.is_finish;
                    r_stat  <= bae_pkg::ST_OK;
                    r_nbits <= '0;
                    r_rdk   <= '0;
                    r_step  <= '0;
                    r_acc   <= '0;
                    r_mq    <= r_high - r_low;
                end
                bae_pkg::S_MUL: begin
                    if (w_limit) begin
                        r_stat <= bae_pkg::ST_LIMIT;
                    end else begin
                        r_acc  <= w_acc_nx;
                        r_mq   <= {r_mq[P-2:0], 1'b0};
                        r_step <= r_step + 1'b1;
                    end
                end
                bae_pkg::S_DIV: begin
                    r_step <= r_step + 1'b1;
                    r_acc  <= {r_acc[bae_pkg::PROD_W-2:0], 1'b0};
                    if (!w_rsub[bae_pkg::REM_W]) begin
                        r_rem <= w_rsub[bae_pkg::REM_W-1:0];
                        r_quo <= {r_quo[P-2:0], 1'b1};
                    end else begin
                        r_rem <= w_rsh[bae_pkg::REM_W-1:0];
                        r_quo <= {r_quo[P-2:0], 1'b0};
                    end
                end
                bae_pkg::S_SPLIT: begin
                    r_guard <= '0;
                    if (r_sym) begin
                        r_low <= (w_mid < r_high) ? w_mid + 1'b1 : r_high;
                        r_oc  <= r_oc + 1'b1;
                    end else begin
                        r_high <= w_mid;
                        r_zc   <= r_zc + 1'b1;
                    end
                end
                bae_pkg::S_NORM: begin
                    if (r_guard != bae_pkg::GUARD_W'(bae_pkg::GUARD_MAX)) begin
                        if (w_e12) begin
                            r_ebit  <= r_high[P-1];
                            r_erem  <= r_pend;
                            r_pend  <= '0;
                            r_high  <= {r_high[P-2:0], 1'b1};
                            r_low   <= {r_low[P-2:0], 1'b0};
                            r_guard <= r_guard + 1'b1;
                        end else if (w_e3) begin
                            r_pend  <= w_pend_inc;
                            if (w_pend_ovf) r_stat <= bae_pkg::ST_PENDOVF;
                            r_high  <= {w_h3[P-2:0], 1'b1};
                            r_low   <= {w_l3[P-2:0], 1'b0};
                            r_guard <= r_guard + 1'b1;
                        end
                    end
                end
                bae_pkg::S_EMIT: r_erem <= r_erem - 1'b1;
                bae_pkg::S_FIN: begin
                    r_ebit <= (r_low >= bae_pkg::IV_QTR);
                    r_erem <= w_pend_inc;
                    if (w_pend_ovf) r_stat <= bae_pkg::ST_PENDOVF;
                    r_pend <= '0;
                    r_low  <= '0;
                    r_high <= bae_pkg::IV_MAX;
                    if (i_adaptive) begin
                        r_zc <= bae_pkg::CNT_W'(1);
                        r_oc <= bae_pkg::CNT_W'(1);
                    end
                end
                bae_pkg::S_SHOW: begin
                    r_out_valid    <= 1'b1;
                    r_out.has_bit  <= (r_nbits != '0);
                    r_out.out_bit  <= (r_nbits != '0) && w_rdata;
                    r_out.status   <= r_stat;
                    r_out.last     <= (r_nbits == '0)
                                   || ({1'b0, r_rdk} == r_nbits - 1'b1);
                end
                bae_pkg::S_WAIT: begin
                    if (w_accept) begin
                        r_out_valid <= 1'b0;
                        r_rdk       <= r_rdk + 1'b1;
                    end
                end
                default: ;
            endcase
            // high half of the full product seeds the divider
            if (r_state == bae_pkg::S_MUL && w_step_end && !w_limit) begin
                r_rem  <= {1'b0, w_acc_nx[bae_pkg::PROD_W-1:P]};
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

endmodule

// File: sv/binary_arithmetic_encoder.sv
// Binary arithmetic encoder over a 16-bit interval with pending-bit carry handling.
// An encode request runs the interval split, then one renormalization shift at a time and
// one flushed pending bit at a time before its first result; results are then delivered
// one at a time, each held until accepted. The split point comes from a 16-step shift-add
// multiplier followed by a 16-step restoring divider in the core. A request that hits the
// count limit skips the split. A finish request writes its final bits, then delivery.
// Up to two requests queue ahead of the core. Depends on bae_pkg, bae_front, bae_core.
module binary_arithmetic_encoder (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  bae_pkg::t_bae_req i_in_req,
    output logic              o_in_stall,
    output logic              o_out_valid,
    output bae_pkg::t_bae_res o_out_res,
    input  logic              i_out_stall,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic                r_adaptive;
    logic [15:0]         r_fixed_p;
    bae_pkg::t_bae_queue w_head;
    logic                w_pop;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adaptive <= 1'b1;
            r_fixed_p  <= 16'd32767;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                bae_pkg::REG_MODE:  r_adaptive <= pwdata[0];
                bae_pkg::REG_FIXED: r_fixed_p  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    assign prdata = (paddr[2] == bae_pkg::REG_FIXED) ? {16'd0, r_fixed_p}
                                                    : {31'd0, r_adaptive};

    bae_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_req   (i_in_req),
        .o_in_stall (o_in_stall),
        .o_head     (w_head),
        .i_pop      (w_pop)
    );

    bae_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adaptive  (r_adaptive),
        .i_fixed_p   (r_fixed_p),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .o_out_res   (o_out_res),
        .i_out_stall (i_out_stall)
    );

endmodule

// File: sv/bae_checker.sv
// port-level checks for the binary arithmetic encoder, bound to the top level
// depends on bae_pkg
module bae_sva (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input bae_pkg::t_bae_res o_out_res,
    input logic              i_out_stall,
    input logic              pready
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_res))
        else $error("stalled result changed");

    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_res.has_bit |-> o_out_res.last && !o_out_res.out_bit)
        else $error("empty result not final");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_res.status != 2'd3)
        else $error("bad status");

    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid && pready)
        else $error("output valid after reset");

endmodule

bind binary_arithmetic_encoder bae_sva u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .o_out_res   (o_out_res),
    .i_out_stall (i_out_stall),
    .pready      (pready)
);
